/* rtl/core/scds_pkg.sv */
// Shared types, widths, register indexes and reset values for the sample clock drift servo.
// Used by scds_div, scds_mul, sample_clock_drift_servo_unit and the testbench. No dependencies.
`default_nettype none

package scds_pkg;

	// Field and register widths.
	localparam int unsigned TIME_W     = 64;
	localparam int unsigned POS_W      = 48;
	localparam int unsigned RATE_W     = 19;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned THR_W      = 32;
	localparam int unsigned INTV_W     = 40;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned PROD_W     = TIME_W + GAIN_W;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 40;

	// Default fixed-point formats.
	localparam int unsigned DEF_TIME_FRAC_BITS = 32;
	localparam int unsigned DEF_GAIN_FRAC_BITS = 16;

	// Register reset values.
	localparam logic [RATE_W-1:0] RST_SAMPLE_RATE     = RATE_W'(48000);
	localparam logic              RST_FREEWHEEL       = 1'b0;
	localparam logic [GAIN_W-1:0] RST_CONVERGE_GAIN   = GAIN_W'(655);
	localparam logic [THR_W-1:0]  RST_DRIFT_THRESHOLD = THR_W'(21474836);
	localparam logic [INTV_W-1:0] RST_REPORT_INTERVAL = 40'h01_0000_0000;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREEWHEEL       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONVERGE_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = 3'd4;

	// Command codes.
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_REBASE = 1'b1;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SUM,
		ST_DRIFT,
		ST_MAG,
		ST_OVER,
		ST_MUL,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* rtl/core/scds_div.sv */
// Bit-serial restoring divider: floor(dividend * 2^FRAC_BITS / divisor), low TIME_W bits.
// Depends on scds_pkg for field widths.
`default_nettype none

module scds_div #(
	parameter int unsigned FRAC_BITS = scds_pkg::DEF_TIME_FRAC_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [scds_pkg::POS_W-1:0]    dividend,
	input  wire logic [scds_pkg::RATE_W-1:0]   divisor,
	output logic                               done,
	output logic [scds_pkg::TIME_W-1:0]        quotient
);

	localparam int unsigned N  = scds_pkg::POS_W + FRAC_BITS;
	localparam int unsigned CW = $clog2(N);
	localparam int unsigned RW = scds_pkg::RATE_W;

	logic [N-1:0]  dq_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [RW:0] trial;
	logic [RW:0] diff;
	logic        qbit;

	// One quotient bit per cycle: bring down the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, dq_q[N-1]};
		diff  = trial - {1'b0, dsr_q};
		qbit  = (trial >= {1'b0, dsr_q});
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {dividend, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			dsr_q <= (divisor == '0) ? RW'(1) : divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[RW-1:0] : trial[RW-1:0];
			dq_q  <= {dq_q[N-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q[scds_pkg::TIME_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/scds_mul.sv */
// Shift-and-add multiplier, one gain bit per cycle, most significant bit first.
// Depends on scds_pkg for field widths.
`default_nettype none

module scds_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [scds_pkg::TIME_W-1:0]   mcand,
	input  wire logic [scds_pkg::GAIN_W-1:0]   mplier,
	output logic                               done,
	output logic [scds_pkg::PROD_W-1:0]        product
);

	localparam int unsigned GW = scds_pkg::GAIN_W;
	localparam int unsigned PW = scds_pkg::PROD_W;
	localparam int unsigned CW = $clog2(GW);

	logic [PW-1:0]                  acc_q;
	logic [scds_pkg::TIME_W-1:0]    mcand_q;
	logic [GW-1:0]                  gsh_q;
	logic [CW-1:0]                  cnt_q;
	logic                           busy_q;
	logic                           done_q;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(GW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Double the partial sum and add the multiplicand when the next gain bit is set.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			mcand_q <= mcand;
			gsh_q   <= mplier;
		end else if (busy_q) begin
			acc_q <= {acc_q[PW-2:0], 1'b0} + (gsh_q[GW-1] ? PW'(mcand_q) : PW'(0));
			gsh_q <= {gsh_q[GW-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

`default_nettype wire

/* rtl/core/sample_clock_drift_servo_unit.sv */
// Top level of the sample clock drift servo: register file, sequencer and output register.
// Depends on scds_pkg, scds_div and scds_mul.
//
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    command, sample_position, wall_time
// out       source     out_valid / out_ready  clock_time, drift, over_count, log_event
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time: a new beat is taken only in the idle state. An update beat passes the
// bit-serial divider of position by rate, which holds the sequencer until it is done, then
// the drift, magnitude and threshold states and the gain multiplier before its result is
// loaded. Freewheel and rebase items skip the multiplier and go straight from the sum to the
// result.
// The output register lets the next item in while a result beat waits for out_ready.
// Reset restores the register defaults and clears the timebase, counter and report time.
`default_nettype none

module sample_clock_drift_servo_unit #(
	parameter int unsigned TIME_FRAC_BITS = scds_pkg::DEF_TIME_FRAC_BITS,
	parameter int unsigned GAIN_FRAC_BITS = scds_pkg::DEF_GAIN_FRAC_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              command,
	input  wire logic [scds_pkg::POS_W-1:0]        sample_position,
	input  wire logic [scds_pkg::TIME_W-1:0]       wall_time,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [scds_pkg::TIME_W-1:0]            clock_time,
	output logic signed [scds_pkg::TIME_W-1:0]     drift,
	output logic [scds_pkg::CNT_W-1:0]             over_count,
	output logic                                   log_event,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [scds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [scds_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned TW = scds_pkg::TIME_W;

	scds_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [scds_pkg::RATE_W-1:0] rate_q;
	logic                        freewheel_q;
	logic [scds_pkg::GAIN_W-1:0] gain_q;
	logic [scds_pkg::THR_W-1:0]  thr_q;
	logic [scds_pkg::INTV_W-1:0] intv_q;

	// Servo state.
	logic [TW-1:0]              base_q;
	logic [scds_pkg::CNT_W-1:0] cnt_q;
	logic [TW-1:0]              last_q;

	// Per-item working registers.
	logic          cmd_q;
	logic [TW-1:0] wall_q;
	logic [TW-1:0] off_q;
	logic [TW-1:0] sum_q;
	logic [TW-1:0] drift_q;
	logic [TW-1:0] mag_q;
	logic          neg_q;
	logic [TW-1:0] since_q;
	logic          log_q;

	// Output register.
	logic                       out_valid_q;
	logic [TW-1:0]              out_clock_q;
	logic [TW-1:0]              out_drift_q;
	logic [scds_pkg::CNT_W-1:0] out_cnt_q;
	logic                       out_log_q;

	// Sequencer controls.
	logic in_fire;
	logic div_start;
	logic mul_start;
	logic out_load;

	// Unit interfaces.
	logic                          div_done;
	logic [TW-1:0]                 div_quo;
	logic                          mul_done;
	logic [scds_pkg::PROD_W-1:0]   mul_prod;
	logic [TW-1:0]                 corr;
	logic                          over_hit;
	logic                          report_ok;

	scds_div #(
		.FRAC_BITS (TIME_FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sample_position),
		.divisor  (rate_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	scds_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mag_q),
		.mplier  (gain_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	// Correction magnitude, threshold test and report spacing test.
	always_comb begin
		corr      = TW'(mul_prod >> GAIN_FRAC_BITS);
		over_hit  = (mag_q > TW'(thr_q));
		report_ok = !since_q[TW-1] && (since_q >= TW'(intv_q));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scds_pkg::ST_IDLE: begin
				if (in_valid) state_d = scds_pkg::ST_DIV;
			end
			scds_pkg::ST_DIV: begin
				if (div_done) state_d = scds_pkg::ST_SUM;
			end
			scds_pkg::ST_SUM: begin
				if (cmd_q == scds_pkg::CMD_REBASE || freewheel_q) begin
					state_d = scds_pkg::ST_DONE;
				end else begin
					state_d = scds_pkg::ST_DRIFT;
				end
			end
			scds_pkg::ST_DRIFT: state_d = scds_pkg::ST_MAG;
			scds_pkg::ST_MAG:   state_d = scds_pkg::ST_OVER;
			scds_pkg::ST_OVER:  state_d = scds_pkg::ST_MUL;
			scds_pkg::ST_MUL: begin
				if (mul_done) state_d = scds_pkg::ST_DONE;
			end
			scds_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = scds_pkg::ST_IDLE;
			end
			default: state_d = scds_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready  = (state_q == scds_pkg::ST_IDLE);
		in_fire   = in_valid && in_ready;
		div_start = in_fire;
		mul_start = (state_q == scds_pkg::ST_OVER);
		out_load  = (state_q == scds_pkg::ST_DONE) && (!out_valid_q || out_ready);
	end

	// Control state, configuration registers and servo state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scds_pkg::ST_IDLE;
			rate_q      <= scds_pkg::RST_SAMPLE_RATE;
			freewheel_q <= scds_pkg::RST_FREEWHEEL;
			gain_q      <= scds_pkg::RST_CONVERGE_GAIN;
			thr_q       <= scds_pkg::RST_DRIFT_THRESHOLD;
			intv_q      <= scds_pkg::RST_REPORT_INTERVAL;
			base_q      <= '0;
			cnt_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Register writes; indexes beyond the list are dropped.
			if (cfg_valid) begin
				unique case (cfg_index)
					scds_pkg::REG_SAMPLE_RATE:     rate_q      <= cfg_data[scds_pkg::RATE_W-1:0];
					scds_pkg::REG_FREEWHEEL:       freewheel_q <= cfg_data[0];
					scds_pkg::REG_CONVERGE_GAIN:   gain_q      <= cfg_data[scds_pkg::GAIN_W-1:0];
					scds_pkg::REG_DRIFT_THRESHOLD: thr_q       <= cfg_data[scds_pkg::THR_W-1:0];
					scds_pkg::REG_REPORT_INTERVAL: intv_q      <= cfg_data[scds_pkg::INTV_W-1:0];
					default: ;
				endcase
			end

			// A rebase moves the base so that base plus offset equals the wall time.
			if (state_q == scds_pkg::ST_SUM && cmd_q == scds_pkg::CMD_REBASE) begin
				base_q <= wall_q - off_q;
			end

			// Over-threshold bookkeeping.
			if (state_q == scds_pkg::ST_OVER && over_hit) begin
				cnt_q <= cnt_q + scds_pkg::CNT_W'(1);
				if (report_ok) last_q <= wall_q;
			end

			// Move the base by the scaled drift.
			if (state_q == scds_pkg::ST_MUL && mul_done) begin
				base_q <= neg_q ? (base_q - corr) : (base_q + corr);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and the output payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= command;
			wall_q <= wall_time;
		end
		if (div_done) off_q <= div_quo;
		if (state_q == scds_pkg::ST_SUM) begin
			sum_q   <= base_q + off_q;
			drift_q <= '0;
			log_q   <= 1'b0;
		end
		if (state_q == scds_pkg::ST_DRIFT) drift_q <= wall_q - sum_q;
		if (state_q == scds_pkg::ST_MAG) begin
			neg_q   <= drift_q[TW-1];
			mag_q   <= drift_q[TW-1] ? (TW'(0) - drift_q) : drift_q;
			since_q <= wall_q - last_q;
		end
		if (state_q == scds_pkg::ST_OVER) log_q <= over_hit && report_ok;
		if (out_load) begin
			out_clock_q <= base_q + off_q;
			out_drift_q <= drift_q;
			out_cnt_q   <= cnt_q;
			out_log_q   <= log_q;
		end
	end

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign clock_time = out_clock_q;
	assign drift      = $signed(out_drift_q);
	assign over_count = out_cnt_q;
	assign log_event  = out_log_q;

`ifndef SYNTHESIS
	// A reported drift is over a non-negative threshold, so it cannot be zero.
	a_log_needs_drift: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && log_event |-> drift != 0)
		else $error("log flag raised with zero drift");

	// The divider finishes only while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == scds_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	// The multiplier finishes only while the sequencer waits for it.
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == scds_pkg::ST_MUL)
		else $error("multiplier finished outside the multiply state");

	// An accepted input beat starts the divide at once.
	a_accept_divides: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == scds_pkg::ST_DIV)
		else $error("accepted beat did not start the divider");
`endif

endmodule

`default_nettype wire

/* tb/sample_clock_drift_servo_unit_tb.sv */
// Self-checking testbench for sample_clock_drift_servo_unit: a directed table, then random
// update and rebase beats under stalls, each reading checked against an in-place servo or the table.
// Depends on scds_pkg and the unit's RTL only.

module sample_clock_drift_servo_unit_tb;

	localparam int unsigned TFB          = scds_pkg::DEF_TIME_FRAC_BITS;
	localparam int unsigned GFB          = scds_pkg::DEF_GAIN_FRAC_BITS;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned PHASE_BEATS  = 225;
	localparam int unsigned DRAIN_CYCLES = 150;
	localparam int unsigned CYCLE_LIMIT  = 1_200_000;
	localparam int unsigned REPORT_MAX   = 10;
	localparam logic [scds_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam logic [scds_pkg::TIME_W-1:0]    ONE_SEC   = 64'h1_0000_0000;

	typedef struct packed {
		logic [scds_pkg::TIME_W-1:0] clock_time;
		logic [scds_pkg::TIME_W-1:0] drift;
		logic [scds_pkg::CNT_W-1:0]  over_count;
		logic                        log_event;
	} reading_t;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                        kind;
		logic                             cmd;
		logic [scds_pkg::POS_W-1:0]       pos;
		logic [scds_pkg::TIME_W-1:0]      wall;
		logic [scds_pkg::CFG_IDX_W-1:0]   idx;
		logic [scds_pkg::CFG_DATA_W-1:0]  data;
		bit                               fixed;
		reading_t                         want;
	} stim_row_t;

	// Clock, reset and every input of the unit start at known values.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic command = scds_pkg::CMD_UPDATE;
	logic [scds_pkg::POS_W-1:0] sample_position = '0;
	logic [scds_pkg::TIME_W-1:0] wall_time = '0;
	logic out_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic [scds_pkg::CFG_IDX_W-1:0] cfg_index = scds_pkg::REG_SAMPLE_RATE;
	logic [scds_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic in_ready;
	logic cfg_ready;
	logic out_valid;
	logic [scds_pkg::TIME_W-1:0] clock_time;
	logic signed [scds_pkg::TIME_W-1:0] drift;
	logic [scds_pkg::CNT_W-1:0] over_count;
	logic log_event;

	always #5 clk = ~clk;

	sample_clock_drift_servo_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.sample_position (sample_position),
		.wall_time       (wall_time),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.clock_time      (clock_time),
		.drift           (drift),
		.over_count      (over_count),
		.log_event       (log_event),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// Servo registers and timebase as the testbench expects them.
	logic [scds_pkg::RATE_W-1:0] m_rate        = scds_pkg::RST_SAMPLE_RATE;
	logic                        m_freewheel   = scds_pkg::RST_FREEWHEEL;
	logic [scds_pkg::GAIN_W-1:0] m_gain        = scds_pkg::RST_CONVERGE_GAIN;
	logic [scds_pkg::THR_W-1:0]  m_thr         = scds_pkg::RST_DRIFT_THRESHOLD;
	logic [scds_pkg::INTV_W-1:0] m_intv        = scds_pkg::RST_REPORT_INTERVAL;
	logic [scds_pkg::TIME_W-1:0] m_base        = '0;
	logic [scds_pkg::CNT_W-1:0]  m_count       = '0;
	logic [scds_pkg::TIME_W-1:0] m_last_report = '0;

	reading_t    due_readings[$];
	stim_row_t   stim_tab[$];
	bit          idle_en = 1'b1;
	int unsigned stall_left = 0;
	int unsigned n_cycles = 0;
	int unsigned n_beats = 0;
	int unsigned n_rebases = 0;
	int unsigned n_checked = 0;
	int unsigned n_logs = 0;
	int unsigned n_over = 0;
	int unsigned n_errors = 0;

	// Position in samples to Q32.32 seconds; a zero rate counts as one.
	function automatic logic [scds_pkg::TIME_W-1:0] samples_to_time(
			logic [scds_pkg::POS_W-1:0] pos, logic [scds_pkg::RATE_W-1:0] rate);
		logic [63:0] div, whole, rem;
		div = (rate == '0) ? 64'd1 : 64'(rate);
		whole = 64'(pos) / div;
		rem = 64'(pos) % div;
		return (whole << TFB) + ((rem << TFB) / div);
	endfunction

	// Drift magnitude times gain, truncated, modulo 2^64.
	function automatic logic [scds_pkg::TIME_W-1:0] gain_correction(
			logic [scds_pkg::TIME_W-1:0] mag, logic [scds_pkg::GAIN_W-1:0] gain);
		logic [63:0] hi, lo;
		hi = (mag >> 32) * 64'(gain);
		lo = (mag & 64'hFFFF_FFFF) * 64'(gain);
		return (hi << (32 - GFB)) + (lo >> GFB);
	endfunction

	// One servo step: advances the expected timebase and returns the reading it gives.
	function automatic reading_t next_reading(logic cmd, logic [scds_pkg::POS_W-1:0] pos,
			logic [scds_pkg::TIME_W-1:0] wall);
		reading_t r;
		logic [63:0] off, d, mag, corr, since;
		off = samples_to_time(pos, m_rate);
		r = '0;
		if (cmd == scds_pkg::CMD_REBASE) begin
			m_base = wall - off;
		end else if (!m_freewheel) begin
			d = wall - (m_base + off);
			mag = d[63] ? 64'd0 - d : d;
			if (mag > 64'(m_thr)) begin
				m_count++;
				n_over++;
				since = wall - m_last_report;
				if (!since[63] && since >= 64'(m_intv)) begin
					m_last_report = wall;
					r.log_event = 1'b1;
				end
			end
			corr = gain_correction(mag, m_gain);
			m_base = d[63] ? m_base - corr : m_base + corr;
			r.drift = d;
		end
		r.clock_time = m_base + off;
		r.over_count = m_count;
		return r;
	endfunction

	function automatic void store_register(logic [scds_pkg::CFG_IDX_W-1:0] idx,
			logic [scds_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			scds_pkg::REG_SAMPLE_RATE:     m_rate = data[scds_pkg::RATE_W-1:0];
			scds_pkg::REG_FREEWHEEL:       m_freewheel = data[0];
			scds_pkg::REG_CONVERGE_GAIN:   m_gain = data[scds_pkg::GAIN_W-1:0];
			scds_pkg::REG_DRIFT_THRESHOLD: m_thr = data[scds_pkg::THR_W-1:0];
			scds_pkg::REG_REPORT_INTERVAL: m_intv = data[scds_pkg::INTV_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void tab_beat(logic cmd, logic [scds_pkg::POS_W-1:0] pos,
			logic [scds_pkg::TIME_W-1:0] wall, bit fixed, reading_t want);
		stim_row_t row;
		row.kind = ROW_BEAT;
		row.cmd = cmd;
		row.pos = pos;
		row.wall = wall;
		row.idx = '0;
		row.data = '0;
		row.fixed = fixed;
		row.want = want;
		stim_tab.push_back(row);
	endfunction

	function automatic void tab_cfg(logic [scds_pkg::CFG_IDX_W-1:0] idx,
			logic [scds_pkg::CFG_DATA_W-1:0] data);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.cmd = scds_pkg::CMD_UPDATE;
		row.pos = '0;
		row.wall = '0;
		row.idx = idx;
		row.data = data;
		row.fixed = 1'b0;
		row.want = '0;
		stim_tab.push_back(row);
	endfunction

	// Offer one input beat; on acceptance queue the reading it must produce.
	task automatic send_beat(logic cmd, logic [scds_pkg::POS_W-1:0] pos,
			logic [scds_pkg::TIME_W-1:0] wall, bit fixed, reading_t want);
		reading_t r;
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		sample_position <= pos;
		wall_time <= wall;
		do @(posedge clk); while (!in_ready);
		r = next_reading(cmd, pos, wall);
		due_readings.push_back(fixed ? want : r);
		n_beats++;
		if (cmd == scds_pkg::CMD_REBASE) n_rebases++;
	endtask

	task automatic hold_off(int unsigned n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Stop offering beats and wait until every queued reading has come back.
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_readings.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(logic [scds_pkg::CFG_IDX_W-1:0] idx,
			logic [scds_pkg::CFG_DATA_W-1:0] data);
		wait_quiet();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		store_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side back-pressure in random bursts.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest queued reading.
	always @(posedge clk) begin : check_readings
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			n_checked++;
			if (log_event) n_logs++;
			if (due_readings.size() == 0) begin
				n_errors++;
				if (n_errors <= REPORT_MAX)
					$display("unexpected reading: clock %h drift %h count %h log %b",
						clock_time, drift, over_count, log_event);
			end else begin
				want = due_readings.pop_front();
				if (clock_time !== want.clock_time || drift !== want.drift ||
						over_count !== want.over_count || log_event !== want.log_event) begin
					n_errors++;
					if (n_errors <= REPORT_MAX) begin
						$display("reading %0d mismatch (expected / actual):", n_checked);
						$display("  clock %h / %h  drift %h / %h", want.clock_time,
							clock_time, want.drift, drift);
						$display("  count %h / %h  log %b / %b", want.over_count,
							over_count, want.log_event, log_event);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d readings outstanding", n_cycles,
				due_readings.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [scds_pkg::POS_W-1:0]      pos;
		logic [scds_pkg::TIME_W-1:0]     wall, origin, jmag;
		logic [scds_pkg::CFG_DATA_W-1:0] junk;
		logic [scds_pkg::RATE_W-1:0]     rate;
		logic [scds_pkg::GAIN_W-1:0]     gain;
		logic [scds_pkg::THR_W-1:0]      thr;
		logic [scds_pkg::INTV_W-1:0]     intv;
		int unsigned                     pick;

		// An update at zero from reset, then a rebase to 100 s and two steps exactly on time.
		tab_beat(scds_pkg::CMD_UPDATE, 48'd0, 64'd0, 1'b1, {64'd0, 64'd0, 32'd0, 1'b0});
		tab_beat(scds_pkg::CMD_REBASE, 48'd48000, 64'h64_0000_0000, 1'b1,
			{64'h64_0000_0000, 64'd0, 32'd0, 1'b0});
		tab_beat(scds_pkg::CMD_UPDATE, 48'd48000, 64'h64_0000_0000, 1'b1,
			{64'h64_0000_0000, 64'd0, 32'd0, 1'b0});
		tab_beat(scds_pkg::CMD_UPDATE, 48'd96000, 64'h65_0000_0000, 1'b1,
			{64'h65_0000_0000, 64'd0, 32'd0, 1'b0});
		// One second late: over threshold, first report, base moves by gain times drift.
		tab_beat(scds_pkg::CMD_UPDATE, 48'd96000, 64'h66_0000_0000, 1'b1,
			{64'h65_028F_0000, ONE_SEC, 32'd1, 1'b1});
		// Still late, but inside the report interval.
		tab_beat(scds_pkg::CMD_UPDATE, 48'd96000, 64'h66_0000_0000, 1'b0, '0);
		// Wall time behind the last report gives a negative spacing and no report.
		tab_beat(scds_pkg::CMD_UPDATE, 48'd96000, 64'd0, 1'b0, '0);
		tab_beat(scds_pkg::CMD_UPDATE, '1, '1, 1'b0, '0);
		// Drift of exactly half the time range, the most negative value.
		tab_beat(scds_pkg::CMD_REBASE, 48'd0, 64'h0123_4567_89AB_CDEF, 1'b0, '0);
		tab_beat(scds_pkg::CMD_UPDATE, 48'd0, 64'h8123_4567_89AB_CDEF, 1'b0, '0);
		// Freewheel bypasses the servo, while a rebase still takes effect.
		tab_cfg(scds_pkg::REG_FREEWHEEL, 40'd1);
		tab_beat(scds_pkg::CMD_UPDATE, 48'd12345, 64'hFFFF_0000_0000_0000, 1'b0, '0);
		tab_beat(scds_pkg::CMD_REBASE, 48'd1000, 64'h0000_0200_8000_0000, 1'b0, '0);
		tab_beat(scds_pkg::CMD_UPDATE, 48'd2000, 64'd0, 1'b0, '0);
		tab_cfg(scds_pkg::REG_FREEWHEEL, 40'hFF_FFFF_FFFE);
		// A zero rate acts as one sample per second; bits above the register drop off.
		tab_cfg(scds_pkg::REG_SAMPLE_RATE, 40'hFF_FFF8_0000);
		tab_beat(scds_pkg::CMD_UPDATE, 48'd5, 64'h5_0000_0000, 1'b0, '0);
		tab_beat(scds_pkg::CMD_REBASE, '1, 64'd0, 1'b0, '0);
		tab_beat(scds_pkg::CMD_UPDATE, '1, 64'd7, 1'b0, '0);
		// Widest rate, full gain, zero threshold and interval.
		tab_cfg(scds_pkg::REG_SAMPLE_RATE, 40'h7_FFFF);
		tab_cfg(scds_pkg::REG_CONVERGE_GAIN, 40'hFFFF);
		tab_cfg(scds_pkg::REG_DRIFT_THRESHOLD, 40'd0);
		tab_cfg(scds_pkg::REG_REPORT_INTERVAL, 40'd0);
		tab_beat(scds_pkg::CMD_UPDATE, '1, 64'h8000_0000_0000_0001, 1'b0, '0);
		tab_beat(scds_pkg::CMD_UPDATE, 48'd1, 64'd1, 1'b0, '0);
		tab_beat(scds_pkg::CMD_UPDATE, 48'd1, 64'd1, 1'b0, '0);
		// Zero gain holds the base; threshold and interval at their largest.
		tab_cfg(scds_pkg::REG_CONVERGE_GAIN, 40'd0);
		tab_cfg(scds_pkg::REG_DRIFT_THRESHOLD, 40'hFF_FFFF_FFFF);
		tab_cfg(scds_pkg::REG_REPORT_INTERVAL, 40'hFF_FFFF_FFFF);
		tab_beat(scds_pkg::CMD_UPDATE, 48'd384000, 64'h7FFF_0000_0000_0000, 1'b0, '0);
		tab_beat(scds_pkg::CMD_UPDATE, 48'h8000_0000_0000, 64'hFFFF_FFFF_0000_0000, 1'b0, '0);
		// An unmapped index must leave every register alone.
		tab_cfg(REG_SPARE, 40'h12_3456_789A);
		tab_cfg(scds_pkg::REG_SAMPLE_RATE, 40'd1);
		tab_beat(scds_pkg::CMD_UPDATE, '1, 64'h5555_AAAA_5555_AAAA, 1'b0, '0);
		tab_cfg(scds_pkg::REG_SAMPLE_RATE, 40'd384000);
		tab_beat(scds_pkg::CMD_UPDATE, 48'hAAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table.
		foreach (stim_tab[i]) begin
			if (stim_tab[i].kind == ROW_CFG) begin
				write_register(stim_tab[i].idx, stim_tab[i].data);
			end else begin
				if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 4));
				send_beat(stim_tab[i].cmd, stim_tab[i].pos, stim_tab[i].wall,
					stim_tab[i].fixed, stim_tab[i].want);
			end
		end

		// Random phases, each with its own register setting; the last one runs without idling.
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 7))
				0: rate = 19'd48000;
				1: rate = 19'd44100;
				2: rate = 19'd96000;
				3: rate = 19'd384000;
				4: rate = '1;
				5: rate = 19'd1;
				6: rate = '0;
				default: rate = 19'($urandom_range(1, 384000));
			endcase
			case ($urandom_range(0, 3))
				0: gain = scds_pkg::RST_CONVERGE_GAIN;
				1: gain = '0;
				2: gain = '1;
				default: gain = 16'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0: thr = scds_pkg::RST_DRIFT_THRESHOLD;
				1: thr = '0;
				2: thr = '1;
				default: thr = 32'($urandom) >> $urandom_range(0, 31);
			endcase
			case ($urandom_range(0, 3))
				0: intv = scds_pkg::RST_REPORT_INTERVAL;
				1: intv = '0;
				2: intv = '1;
				default: intv = {8'($urandom), 32'($urandom)} >> $urandom_range(0, 39);
			endcase
			junk = {8'($urandom), 32'($urandom)};
			write_register(scds_pkg::REG_SAMPLE_RATE,
				{junk[scds_pkg::CFG_DATA_W-1:scds_pkg::RATE_W], rate});
			write_register(scds_pkg::REG_FREEWHEEL, {junk[scds_pkg::CFG_DATA_W-1:1], (ph == 2)});
			write_register(scds_pkg::REG_CONVERGE_GAIN,
				{junk[scds_pkg::CFG_DATA_W-1:scds_pkg::GAIN_W], gain});
			write_register(scds_pkg::REG_DRIFT_THRESHOLD,
				{junk[scds_pkg::CFG_DATA_W-1:scds_pkg::THR_W], thr});
			write_register(scds_pkg::REG_REPORT_INTERVAL, intv);
			idle_en = (ph != PHASES - 1);

			// Each phase opens a well-formed run with a rebase at a random wall time.
			pos = {16'($urandom), 32'($urandom)} >> $urandom_range(0, 24);
			wall = {$urandom, $urandom};
			origin = wall - samples_to_time(pos, m_rate);
			send_beat(scds_pkg::CMD_REBASE, pos, wall, 1'b0, '0);

			for (int k = 0; k < PHASE_BEATS; k++) begin
				if (idle_en && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 4));
				if ($urandom_range(0, 99) == 0) wait_quiet();
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					// Noise: any command, any position, any wall time.
					send_beat(1'($urandom), {16'($urandom), 32'($urandom)},
						{$urandom, $urandom}, 1'b0, '0);
				end else begin
					// Audio advances, wall time follows it with jitter around the threshold.
					pos = pos + 48'($urandom_range(1, 4096));
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: jmag = 64'($urandom_range(0, 1 << 20));
						5, 6, 7: jmag = 64'(m_thr) + 64'($urandom_range(0, 1 << 16)) - 64'd32768;
						default: jmag = 64'($urandom) << $urandom_range(0, 8);
					endcase
					if ($urandom_range(0, 1) == 1) jmag = 64'd0 - jmag;
					wall = origin + samples_to_time(pos, m_rate) + jmag;
					if (pick < 19) begin
						origin = wall - samples_to_time(pos, m_rate);
						send_beat(scds_pkg::CMD_REBASE, pos, wall, 1'b0, '0);
					end else begin
						send_beat(scds_pkg::CMD_UPDATE, pos, wall, 1'b0, '0);
					end
				end
			end
		end

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d beats (%0d rebases) over %0d register settings, %0d readings checked.",
			n_beats, n_rebases, PHASES + 1, n_checked);
		$display("Over-threshold steps %0d, log flags %0d, errors %0d.", n_over, n_logs, n_errors);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/scds_pkg.sv
rtl/core/scds_div.sv
rtl/core/scds_mul.sv
rtl/core/sample_clock_drift_servo_unit.sv
tb/sample_clock_drift_servo_unit_tb.sv
